// ----- rtl/core/povq_pkg.sv -----
`timescale 1ns / 1ps
// shared types and codes for the priority-ordered vehicle queue
package povq_pkg;

	// operation codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_POP    = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam int ID_W   = 16;
	localparam int PRIO_W = 8;
	localparam int OCC_W  = 5;

	// one stored entry
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/core/povq_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module povq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/priority_ordered_vehicle_queue.sv -----
`timescale 1ns / 1ps
// top level of the priority-ordered vehicle queue
//
//  channel   handshake            word
//  command   start / busy         mode, vehicle_id, priority_req
//  result    done (one cycle)     status, out_id, out_priority, occupancy
//
// ram walk: one ram port pair is walked one entry a cycle. insert walks down from the tail,
//   moving each lower-priority entry up, and writes an empty queue directly; pop and remove
//   walk the whole occupancy from the head; full, empty and unused modes answer without a
//   ram walk.
// done is high in the first cycle with busy low; a new command may start in that cycle.
// reset clears the count and the sequencer; the ram contents need no clearing.
// results cannot be stalled: each is shown for exactly one cycle.
module priority_ordered_vehicle_queue
	import povq_pkg::*;
#(
	parameter int DEPTH = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        mode,
	input  logic [ID_W-1:0]   vehicle_id,
	input  logic [PRIO_W-1:0] priority_req,
	output logic              done,
	output logic [1:0]        status,
	output logic [ID_W-1:0]   out_id,
	output logic [PRIO_W-1:0] out_priority,
	output logic [OCC_W-1:0]  occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_IRD,
		S_ICMP,
		S_IPUT,
		S_RRD,
		S_RCMP
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       idx_q;
	logic [CW-1:0]       cnt_q;
	logic [1:0]          mode_q;
	entry_t              new_q;
	logic                found_q;
	entry_t              hit_q;
	logic                done_q;
	logic [1:0]          status_q;
	logic [ID_W-1:0]     out_id_q;
	logic [PRIO_W-1:0]   out_pri_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	entry_t              ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;
	entry_t              rd;
	logic                hit;
	logic                last;
	logic                shift_up;

	assign rd = entry_t'(ram_rdata);

	povq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// compare results of the current walk step
	assign shift_up = (rd.prio < new_q.prio);
	assign hit      = !found_q && ((mode_q == MODE_POP) || (rd.id == new_q.id));
	assign last     = (CW'(idx_q) == (cnt_q - CW'(1)));

	// ram addressing: insert walks down from the tail, pop/remove walk up from the head
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = new_q;
		ram_raddr = idx_q;
		case (state_q)
			S_IRD: begin
				ram_raddr = AW'(cnt_q - CW'(1));
			end
			S_ICMP: begin
				ram_we = 1'b1;
				if (shift_up) begin
					ram_wdata = rd;
					ram_raddr = (idx_q >= AW'(2)) ? (idx_q - AW'(2)) : '0;
				end
			end
			S_IPUT: begin
				ram_we = 1'b1;
			end
			S_RRD: begin
				ram_raddr = '0;
			end
			S_RCMP: begin
				ram_raddr = last ? idx_q : (idx_q + AW'(1));
				if (found_q) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q - AW'(1);
					ram_wdata = rd;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sequencer, count and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			cnt_q     <= '0;
			mode_q    <= MODE_INSERT;
			new_q     <= '0;
			found_q   <= 1'b0;
			hit_q     <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			out_id_q  <= '0;
			out_pri_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q    <= mode;
						new_q     <= '{id: vehicle_id, prio: priority_req};
						found_q   <= 1'b0;
						idx_q     <= '0;
						status_q  <= ST_OK;
						out_id_q  <= '0;
						out_pri_q <= '0;
						case (mode)
							MODE_INSERT: begin
								if (cnt_q == CW'(DEPTH)) begin
									done_q   <= 1'b1;
									status_q <= ST_FULL;
								end else if (cnt_q == '0) begin
									state_q <= S_IPUT;
								end else begin
									idx_q   <= AW'(cnt_q);
									state_q <= S_IRD;
								end
							end
							MODE_POP: begin
								if (cnt_q == '0) begin
									done_q   <= 1'b1;
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_RRD;
								end
							end
							MODE_REMOVE: begin
								if (cnt_q == '0) begin
									done_q   <= 1'b1;
									status_q <= ST_NOTFOUND;
								end else begin
									state_q <= S_RRD;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_IRD: begin
					state_q <= S_ICMP;
				end
				// move one lower-priority entry up, or drop the new one into the gap
				S_ICMP: begin
					if (shift_up) begin
						if (idx_q == AW'(1)) begin
							idx_q   <= '0;
							state_q <= S_IPUT;
						end else begin
							idx_q <= idx_q - AW'(1);
						end
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_IPUT: begin
					cnt_q   <= cnt_q + CW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RRD: begin
					state_q <= S_RCMP;
				end
				// search for the match, then close the gap behind it
				S_RCMP: begin
					if (hit) begin
						found_q <= 1'b1;
						hit_q   <= rd;
					end
					if (last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (found_q || hit) begin
							cnt_q     <= cnt_q - CW'(1);
							out_id_q  <= hit ? rd.id : hit_q.id;
							out_pri_q <= hit ? rd.prio : hit_q.prio;
						end else begin
							status_q <= ST_NOTFOUND;
						end
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign out_id       = out_id_q;
	assign out_priority = out_pri_q;
	assign occupancy    = OCC_W'(cnt_q);

endmodule

// ----- rtl/core/povq_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the priority-ordered vehicle queue, bound to the top level
module povq_checker
	import povq_pkg::*;
#(
	parameter int DEPTH = 20
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [1:0]        status,
	input logic [ID_W-1:0]   out_id,
	input logic [PRIO_W-1:0] out_priority,
	input logic [OCC_W-1:0]  occupancy
);

	// an accepted command either answers at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither busy nor answered");

	// the end of a busy stretch always produces a result
	a_busy_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	// failed operations return no entry
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> ((out_id == '0) && (out_priority == '0)))
		else $error("failed operation returned entry data");

	// full only at capacity, empty only with nothing held
	a_full_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (((status != ST_FULL) || (occupancy == OCC_W'(DEPTH)))
			&& ((status != ST_EMPTY) || (occupancy == '0))))
		else $error("full or empty status disagrees with occupancy");

endmodule

bind priority_ordered_vehicle_queue povq_checker #(
	.DEPTH(DEPTH)
) u_povq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.out_id      (out_id),
	.out_priority(out_priority),
	.occupancy   (occupancy)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the priority-ordered vehicle queue: directed table, then random words
module testbench;
	import povq_pkg::*;

	localparam int QUEUE_DEPTH = 20;
	localparam int RANDOM_WORDS = 640;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// one result word as the block reports it
	typedef struct packed {
		logic [1:0]        st;
		logic [ID_W-1:0]   vid;
		logic [PRIO_W-1:0] pri;
		logic [OCC_W-1:0]  occ;
	} queue_result_t;

	// one directed row: a command, how often to repeat it, and an optional typed result
	typedef struct packed {
		logic [1:0]        op;
		logic [ID_W-1:0]   vid;
		logic [PRIO_W-1:0] pri;
		logic [5:0]        reps;
		logic              typed;
		queue_result_t     want;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        mode = MODE_INSERT;
	logic [ID_W-1:0]   vehicle_id = '0;
	logic [PRIO_W-1:0] priority_req = '0;
	logic              busy;
	logic              done;
	logic [1:0]        status;
	logic [ID_W-1:0]   out_id;
	logic [PRIO_W-1:0] out_priority;
	logic [OCC_W-1:0]  occupancy;

	entry_t        held_entries[$];
	queue_result_t pending_results[$];
	int            mismatch_count = 0;
	bit            idle_off = 1'b0;
	stim_row_t     directed_rows[16];

	priority_ordered_vehicle_queue #(
		.DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.vehicle_id(vehicle_id),
		.priority_req(priority_req),
		.done(done),
		.status(status),
		.out_id(out_id),
		.out_priority(out_priority),
		.occupancy(occupancy)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// hard limit on the run
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	// apply one command to the sorted queue copy and return the result it gives
	function automatic queue_result_t queue_apply(input logic [1:0] op,
			input logic [ID_W-1:0] vid, input logic [PRIO_W-1:0] pri);
		queue_result_t r;
		entry_t        e;
		int            pos;
		r = '0;
		r.st = ST_OK;
		case (op)
			MODE_INSERT: begin
				if (held_entries.size() >= QUEUE_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					// new entry goes behind every entry of equal or higher priority
					pos = 0;
					while (pos < held_entries.size() && held_entries[pos].prio >= pri)
						pos++;
					e.id = vid;
					e.prio = pri;
					held_entries.insert(pos, e);
				end
			end
			MODE_POP: begin
				if (held_entries.size() == 0) begin
					r.st = ST_EMPTY;
				end else begin
					e = held_entries.pop_front();
					r.vid = e.id;
					r.pri = e.prio;
				end
			end
			MODE_REMOVE: begin
				// first match in queue order
				pos = -1;
				for (int k = 0; k < held_entries.size(); k++) begin
					if (pos < 0 && held_entries[k].id == vid)
						pos = k;
				end
				if (pos < 0) begin
					r.st = ST_NOTFOUND;
				end else begin
					r.vid = held_entries[pos].id;
					r.pri = held_entries[pos].prio;
					held_entries.delete(pos);
				end
			end
			default: ;
		endcase
		r.occ = OCC_W'(held_entries.size());
		return r;
	endfunction

	// present one command word, wait for it to be taken, record what it must give
	task automatic send_word(input logic [1:0] op, input logic [ID_W-1:0] vid,
			input logic [PRIO_W-1:0] pri, input logic typed, input queue_result_t want);
		int            gap;
		queue_result_t r;
		gap = idle_off ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= op;
		vehicle_id <= vid;
		priority_req <= pri;
		do @(posedge clk); while (busy);
		r = queue_apply(op, vid, pri);
		pending_results.push_back(typed ? want : r);
	endtask

	// result checker
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", {status, out_id, out_priority, occupancy}, 0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					report_mismatch("status", status, want.st);
				if (out_id !== want.vid)
					report_mismatch("out_id", out_id, want.vid);
				if (out_priority !== want.pri)
					report_mismatch("out_priority", out_priority, want.pri);
				if (occupancy !== want.occ)
					report_mismatch("occupancy", occupancy, want.occ);
			end
		end
	end

	// stimulus
	initial begin
		logic [1:0]        op;
		logic [ID_W-1:0]   vid;
		logic [PRIO_W-1:0] pri;
		int                roll;
		int                insert_pct;
		int                sent;
		int                phase_left;
		int                guard;

		// directed rows; insert rows with reps above one use random content, untyped rows the predictor
		directed_rows = '{
			'{MODE_POP,    16'h0000, 8'h00, 6'd1,  1'b1, '{ST_EMPTY,    16'h0000, 8'h00, 5'd0}},
			'{MODE_REMOVE, 16'h0000, 8'h00, 6'd1,  1'b1, '{ST_NOTFOUND, 16'h0000, 8'h00, 5'd0}},
			'{MODE_UNUSED, 16'hFFFF, 8'hFF, 6'd1,  1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd0}},
			'{MODE_INSERT, 16'hFFFF, 8'hFF, 6'd1,  1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd1}},
			'{MODE_INSERT, 16'h0000, 8'h00, 6'd1,  1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd2}},
			'{MODE_INSERT, 16'h1234, 8'hFF, 6'd1,  1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd3}},
			'{MODE_INSERT, 16'hAAAA, 8'h80, 6'd1,  1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd4}},
			'{MODE_INSERT, 16'h5555, 8'h7F, 6'd1,  1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd5}},
			'{MODE_REMOVE, 16'h1234, 8'h00, 6'd1,  1'b1, '{ST_OK,       16'h1234, 8'hFF, 5'd4}},
			'{MODE_REMOVE, 16'h9999, 8'h00, 6'd1,  1'b1, '{ST_NOTFOUND, 16'h0000, 8'h00, 5'd4}},
			'{MODE_POP,    16'h0000, 8'h00, 6'd1,  1'b1, '{ST_OK,       16'hFFFF, 8'hFF, 5'd3}},
			'{MODE_INSERT, 16'h0000, 8'h00, 6'd17, 1'b0, '{ST_OK,       16'h0000, 8'h00, 5'd0}},
			'{MODE_INSERT, 16'h0F0F, 8'h33, 6'd1,  1'b1, '{ST_FULL,     16'h0000, 8'h00, 5'd20}},
			'{MODE_UNUSED, 16'h0000, 8'h00, 6'd1,  1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd20}},
			'{MODE_REMOVE, 16'h0000, 8'h00, 6'd1,  1'b0, '{ST_OK,       16'h0000, 8'h00, 5'd0}},
			'{MODE_POP,    16'hFFFF, 8'hFF, 6'd21, 1'b0, '{ST_OK,       16'h0000, 8'h00, 5'd0}}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (directed_rows[i]) begin
			for (int j = 0; j < directed_rows[i].reps; j++) begin
				vid = directed_rows[i].vid;
				pri = directed_rows[i].pri;
				if (directed_rows[i].reps > 1 && directed_rows[i].op == MODE_INSERT) begin
					vid = ID_W'($urandom_range(0, 65535));
					pri = PRIO_W'($urandom_range(0, 255));
				end
				send_word(directed_rows[i].op, vid, pri, directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		// random part in phases that lean toward filling, draining or neither
		sent = 0;
		phase_left = 0;
		insert_pct = 45;
		while (sent < RANDOM_WORDS) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 60);
				case ($urandom_range(0, 2))
					0: insert_pct = 75;
					1: insert_pct = 20;
					default: insert_pct = 45;
				endcase
				idle_off = ($urandom_range(0, 3) == 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = MODE_UNUSED;
			else if (roll < 3 + insert_pct)
				op = MODE_INSERT;
			else if (roll < 3 + insert_pct + (97 - insert_pct) / 2)
				op = MODE_POP;
			else
				op = MODE_REMOVE;
			// small id pool makes duplicates and hits likely
			if ($urandom_range(0, 9) < 3)
				vid = ID_W'($urandom_range(0, 65535));
			else
				vid = ID_W'($urandom_range(0, 7) * 32'h2493);
			if (op == MODE_REMOVE && held_entries.size() > 0 && $urandom_range(0, 9) < 6)
				vid = held_entries[$urandom_range(0, held_entries.size() - 1)].id;
			// few priority values give ties
			if ($urandom_range(0, 9) < 3)
				pri = PRIO_W'($urandom_range(0, 3));
			else
				pri = PRIO_W'($urandom_range(0, 255));
			send_word(op, vid, pri, 1'b0, '0);
			if (op != MODE_UNUSED)
				sent++;
			phase_left--;
		end
		start <= 1'b0;

		// wait for the last words, then a short drain
		guard = 0;
		while (pending_results.size() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
